FILE: hw/rtl/ssfl_pkg.sv
package ssfl_pkg;

	// Fixed field widths of the request and response transactions
	localparam int unsigned ADDR_FIELD_W = 32;
	localparam int unsigned ID_W         = 16;
	localparam int unsigned FLAGS_W      = 32;
	localparam int unsigned OFFSET_W     = 32;
	localparam int unsigned STATUS_W     = 3;

	// Defaults for the top-level parameters
	localparam int unsigned DEF_TABLE_DEPTH = 256;
	localparam int unsigned DEF_ADDR_BITS   = 32;

	// Request kinds
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Response status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DISABLED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_STRIPPED  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOKUPS_DISABLED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_STRIPPED   = 1'd1;

endpackage

FILE: hw/rtl/ssfl_if.sv
// Request channel: insert or lookup
interface ssfl_req_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic [ssfl_pkg::ADDR_FIELD_W-1:0]   address;
	logic [ssfl_pkg::ID_W-1:0]           symbol_id;
	logic [ssfl_pkg::FLAGS_W-1:0]        symbol_flags;

	modport source (output valid, req_type, address, symbol_id, symbol_flags, input ready);
	modport sink   (input valid, req_type, address, symbol_id, symbol_flags, output ready);
endinterface

// Response channel: one per request
interface ssfl_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [ssfl_pkg::STATUS_W-1:0]   status;
	logic [ssfl_pkg::ID_W-1:0]       found_id;
	logic [ssfl_pkg::OFFSET_W-1:0]   found_offset;
	logic [ssfl_pkg::FLAGS_W-1:0]    found_flags;

	modport source (output valid, status, found_id, found_offset, found_flags, input ready);
	modport sink   (input valid, status, found_id, found_offset, found_flags, output ready);
endinterface

FILE: hw/rtl/ssfl_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle
module ssfl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/sorted_symbol_floor_lookup.sv
// Sorted symbol table with floor lookup. Entries (address, id, flags) are kept in address order
// in one table RAM with a registered read port, and transactions walk that RAM under a
// small sequencer; req.ready is high only while the sequencer is idle, and one response follows
// each request. An insert moves the s entries not below the new address up by one slot, each
// through S_INS_RD and S_INS_CHK, and writes the new entry into the freed slot (slot 0 straight
// from S_INS_RD); an insert into a full table, and any lookup while lookups_disabled or
// image_stripped is set, goes straight to S_RESULT. A lookup runs a binary search for the first
// entry above the queried address, each probe reading the RAM in S_LKP_RD and comparing in
// S_LKP_CHK. A result also waits while an earlier response is still held by rsp.ready, and
// req.ready returns with rsp.valid. The table RAM has no reset and needs no clearing: only the
// first entry_count entries are ever read. The last entry never matches, and an address below
// the first entry answers not_found. Configuration is written through cfg_we, cfg_index and
// cfg_wdata; the user must do this only while the block is idle, which it does not enforce.
module sorted_symbol_floor_lookup #(
	parameter int unsigned TABLE_DEPTH = ssfl_pkg::DEF_TABLE_DEPTH,
	parameter int unsigned ADDR_BITS   = ssfl_pkg::DEF_ADDR_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ssfl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssfl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	ssfl_req_if.sink                         req,
	ssfl_rsp_if.source                       rsp
);

	localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned WORD_W = ADDR_BITS + ssfl_pkg::ID_W + ssfl_pkg::FLAGS_W;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_INS_RD   = 7'b0000010,
		S_INS_CHK  = 7'b0000100,
		S_LKP_RD   = 7'b0001000,
		S_LKP_CHK  = 7'b0010000,
		S_LKP_DATA = 7'b0100000,
		S_RESULT   = 7'b1000000
	} fsm_t;

	fsm_t state_q;
	logic [CNT_W-1:0] count_q;
	logic lookups_disabled_q;
	logic image_stripped_q;
	logic ovalid_q;

	// Working registers of the current transaction
	logic [CNT_W-1:0]               lo_q;
	logic [CNT_W-1:0]               hi_q;
	logic [IDX_W-1:0]               mid_q;
	logic [ADDR_BITS-1:0]           req_addr_q;
	logic [ssfl_pkg::ID_W-1:0]      req_id_q;
	logic [ssfl_pkg::FLAGS_W-1:0]   req_flags_q;
	logic [ssfl_pkg::STATUS_W-1:0]  res_status_q;
	logic [ssfl_pkg::ID_W-1:0]      res_id_q;
	logic [ssfl_pkg::OFFSET_W-1:0]  res_offset_q;
	logic [ssfl_pkg::FLAGS_W-1:0]   res_flags_q;

	// Output register
	logic [ssfl_pkg::STATUS_W-1:0]  o_status_q;
	logic [ssfl_pkg::ID_W-1:0]      o_id_q;
	logic [ssfl_pkg::OFFSET_W-1:0]  o_offset_q;
	logic [ssfl_pkg::FLAGS_W-1:0]   o_flags_q;

	// RAM port signals
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [WORD_W-1:0]    ram_wdata;
	logic [IDX_W-1:0]     ram_raddr;
	logic [WORD_W-1:0]    ram_rdata;

	logic [ADDR_BITS-1:0]          rd_addr;
	logic [ssfl_pkg::ID_W-1:0]     rd_id;
	logic [ssfl_pkg::FLAGS_W-1:0]  rd_flags;
	logic [ADDR_BITS-1:0]          in_addr;
	logic [CNT_W:0]                mid_sum;
	logic [IDX_W-1:0]              mid;
	logic                          accept;
	logic                          table_full;
	logic                          search_done;
	logic                          entry_not_below;
	logic                          entry_above;
	logic                          out_load;
	logic [WORD_W-1:0]             new_word;

	assign accept      = req.valid && req.ready;
	assign req.ready   = (state_q == S_IDLE);
	assign in_addr     = ADDR_BITS'(req.address);
	assign table_full  = (count_q == CNT_W'(TABLE_DEPTH));
	assign new_word    = {req_addr_q, req_id_q, req_flags_q};

	// Fields of the word read from the table
	assign rd_addr  = ram_rdata[WORD_W-1 -: ADDR_BITS];
	assign rd_id    = ram_rdata[ssfl_pkg::FLAGS_W +: ssfl_pkg::ID_W];
	assign rd_flags = ram_rdata[ssfl_pkg::FLAGS_W-1:0];

	// Entry comparators and search midpoint
	assign entry_not_below = (rd_addr >= req_addr_q);
	assign entry_above     = (rd_addr > req_addr_q);
	assign search_done     = (lo_q == hi_q);
	assign mid_sum         = (CNT_W + 1)'(lo_q) + (CNT_W + 1)'(hi_q);
	assign mid             = IDX_W'(mid_sum >> 1);

	assign out_load = (state_q == S_RESULT) && (!ovalid_q || rsp.ready);

	// RAM addressing per sequencer step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(hi_q);
		ram_wdata = new_word;
		ram_raddr = mid;
		case (state_q)
			S_INS_RD: begin
				ram_raddr = IDX_W'(hi_q - CNT_W'(1));
				if (hi_q == '0) begin
					ram_we = 1'b1;
				end
			end
			S_INS_CHK: begin
				ram_we = 1'b1;
				if (entry_not_below) begin
					ram_wdata = ram_rdata;
				end
			end
			S_LKP_RD: begin
				if (search_done) begin
					ram_raddr = IDX_W'(lo_q - CNT_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	ssfl_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer, entry count, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= S_IDLE;
			count_q            <= '0;
			lookups_disabled_q <= 1'b0;
			image_stripped_q   <= 1'b0;
			ovalid_q           <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ssfl_pkg::CFG_LOOKUPS_DISABLED: lookups_disabled_q <= cfg_wdata[0];
					ssfl_pkg::CFG_IMAGE_STRIPPED:   image_stripped_q   <= cfg_wdata[0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.req_type == ssfl_pkg::REQ_INSERT) begin
							state_q <= table_full ? S_RESULT : S_INS_RD;
						end else if (lookups_disabled_q || image_stripped_q) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_LKP_RD;
						end
					end
				end
				S_INS_RD: begin
					if (hi_q == '0) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_RESULT;
					end else begin
						state_q <= S_INS_CHK;
					end
				end
				S_INS_CHK: begin
					if (entry_not_below) begin
						state_q <= S_INS_RD;
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_RESULT;
					end
				end
				S_LKP_RD: begin
					if (!search_done) begin
						state_q <= S_LKP_CHK;
					end else if (lo_q == '0 || lo_q == count_q) begin
						state_q <= S_RESULT;
					end else begin
						state_q <= S_LKP_DATA;
					end
				end
				S_LKP_CHK:  state_q <= S_LKP_RD;
				S_LKP_DATA: state_q <= S_RESULT;
				S_RESULT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Transaction working registers and result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_addr_q   <= in_addr;
				req_id_q     <= req.symbol_id;
				req_flags_q  <= req.symbol_flags;
				lo_q         <= '0;
				hi_q         <= count_q;
				res_id_q     <= '0;
				res_offset_q <= '0;
				res_flags_q  <= '0;
				if (req.req_type == ssfl_pkg::REQ_INSERT) begin
					res_status_q <= table_full ? ssfl_pkg::ST_FULL : ssfl_pkg::ST_INSERTED;
				end else if (lookups_disabled_q) begin
					res_status_q <= ssfl_pkg::ST_DISABLED;
				end else if (image_stripped_q) begin
					res_status_q <= ssfl_pkg::ST_STRIPPED;
				end else begin
					res_status_q <= ssfl_pkg::ST_NOT_FOUND;
				end
			end
			S_INS_CHK: begin
				if (entry_not_below) begin
					hi_q <= hi_q - CNT_W'(1);
				end
			end
			S_LKP_RD: begin
				mid_q <= mid;
			end
			S_LKP_CHK: begin
				if (entry_above) begin
					hi_q <= CNT_W'(mid_q);
				end else begin
					lo_q <= CNT_W'(mid_q) + CNT_W'(1);
				end
			end
			S_LKP_DATA: begin
				res_status_q <= ssfl_pkg::ST_FOUND;
				res_id_q     <= rd_id;
				res_offset_q <= ssfl_pkg::OFFSET_W'(req_addr_q - rd_addr);
				res_flags_q  <= rd_flags;
			end
			default: begin
			end
		endcase

		if (out_load) begin
			o_status_q <= res_status_q;
			o_id_q     <= res_id_q;
			o_offset_q <= res_offset_q;
			o_flags_q  <= res_flags_q;
		end
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.status       = o_status_q;
	assign rsp.found_id     = o_id_q;
	assign rsp.found_offset = o_offset_q;
	assign rsp.found_flags  = o_flags_q;

endmodule

FILE: hw/rtl/ssfl_checker.sv
// Port-level checks for the symbol table
module ssfl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [ssfl_pkg::STATUS_W-1:0]    status,
	input logic [ssfl_pkg::ID_W-1:0]        found_id,
	input logic [ssfl_pkg::OFFSET_W-1:0]    found_offset,
	input logic [ssfl_pkg::FLAGS_W-1:0]     found_flags
);

	// A stalled response keeps its status
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
		else $error("response changed while stalled");

	// Match fields are zero unless a symbol was found
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ssfl_pkg::ST_FOUND |->
			found_id == '0 && found_offset == '0 && found_flags == '0)
		else $error("non-zero match fields without a match");

	// One transaction at a time: busy right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// A fresh response only comes out of a busy period
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("response without work");

endmodule

bind sorted_symbol_floor_lookup ssfl_checker u_ssfl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.found_id     (rsp.found_id),
	.found_offset (rsp.found_offset),
	.found_flags  (rsp.found_flags)
);
